FILE: rtl/c6502alu_pkg.sv
// shared types, operation codes and helper functions for the 6502-style execute core
// no dependencies
package c6502alu_pkg;

    typedef enum logic [5:0] {
        OP_LDA = 6'd0,
        OP_LDX = 6'd1,
        OP_LDY = 6'd2,
        OP_TAX = 6'd3,
        OP_TAY = 6'd4,
        OP_TSX = 6'd5,
        OP_TXA = 6'd6,
        OP_TXS = 6'd7,
        OP_TYA = 6'd8,
        OP_ADC = 6'd9,
        OP_SBC = 6'd10,
        OP_CMP = 6'd11,
        OP_CPX = 6'd12,
        OP_CPY = 6'd13,
        OP_ASL = 6'd14,
        OP_LSR = 6'd15,
        OP_ROL = 6'd16,
        OP_ROR = 6'd17,
        OP_CLC = 6'd18,
        OP_SEC = 6'd19,
        OP_CLI = 6'd20,
        OP_SEI = 6'd21,
        OP_CLD = 6'd22,
        OP_SED = 6'd23,
        OP_CLV = 6'd24,
        OP_NOP = 6'd25,
        OP_SLO = 6'd26,
        OP_RLA = 6'd27,
        OP_SRE = 6'd28,
        OP_RRA = 6'd29,
        OP_STA = 6'd30,
        OP_STX = 6'd31,
        OP_STY = 6'd32
    } t_op;

    typedef enum logic [1:0] {
        SH_ASL = 2'd0,
        SH_LSR = 2'd1,
        SH_ROL = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } t_regs;

    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    localparam logic [7:0] RST_A  = 8'h00;
    localparam logic [7:0] RST_X  = 8'h00;
    localparam logic [7:0] RST_Y  = 8'h00;
    localparam logic [7:0] RST_SP = 8'hFD;
    localparam logic [7:0] RST_P  = 8'h24;

    // returns {carry, overflow, sum}
    function automatic logic [9:0] f_adc(input logic [7:0] a, input logic [7:0] m,
                                         input logic cin);
        logic [8:0] sum;
        logic       ovf;
        sum = {1'b0, a} + {1'b0, m} + {8'd0, cin};
        ovf = (sum[7] ^ a[7]) & (sum[7] ^ m[7]);
        return {sum[8], ovf, sum[7:0]};
    endfunction

    // returns {carry, negative, zero}
    function automatic logic [2:0] f_cmp(input logic [7:0] r, input logic [7:0] m);
        logic [8:0] d;
        d = {1'b0, r} - {1'b0, m};
        return {~d[8], d[7], (r == m)};
    endfunction

    // returns {carry out, shifted byte}
    function automatic logic [8:0] f_shift(input t_shift kind, input logic [7:0] v,
                                           input logic cin);
        logic [8:0] res;
        unique case (kind)
            SH_ASL: res = {v[7], v[6:0], 1'b0};
            SH_LSR: res = {v[0], 1'b0, v[7:1]};
            SH_ROL: res = {v[7], v[6:0], cin};
            SH_ROR: res = {v[0], cin, v[7:1]};
            default: res = {v[0], cin, v[7:1]};
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/c6502alu_alu.sv
// combinational execute logic: next register file and store byte for one operation
// depends on c6502alu_pkg
module c6502alu_alu
    import c6502alu_pkg::*;
(
    input  t_regs      i_cur,
    input  logic [5:0] i_operation,
    input  logic [7:0] i_operand,
    input  logic       i_on_accumulator,
    output t_regs      o_nxt,
    output logic [7:0] o_store_data,
    output logic       o_store_enable
);

    t_op        op;
    logic [7:0] sh_src;
    logic [8:0] sr;
    logic [9:0] ar;
    logic [2:0] cr;

    assign op     = t_op'(i_operation);
    assign sh_src = i_on_accumulator ? i_cur.a : i_operand;

    always_comb begin
        o_nxt          = i_cur;
        o_store_data   = 8'h00;
        o_store_enable = 1'b0;
        sr             = 9'd0;
        ar             = 10'd0;
        cr             = 3'd0;
        unique case (op)
            OP_LDA: begin
                o_nxt.a = i_operand;
            end
            OP_LDX: begin
                o_nxt.x = i_operand;
            end
            OP_LDY: begin
                o_nxt.y = i_operand;
            end
            OP_TAX: begin
                o_nxt.x = i_cur.a;
            end
            OP_TAY: begin
                o_nxt.y = i_cur.a;
            end
            OP_TSX: begin
                o_nxt.x = i_cur.sp;
            end
            OP_TXA: begin
                o_nxt.a = i_cur.x;
            end
            OP_TXS: begin
                o_nxt.sp = i_cur.x;
            end
            OP_TYA: begin
                o_nxt.a = i_cur.y;
            end
            OP_ADC, OP_SBC: begin
                ar = f_adc(i_cur.a, (op == OP_SBC) ? ~i_operand : i_operand,
                           i_cur.p[FL_C]);
                o_nxt.a       = ar[7:0];
                o_nxt.p[FL_C] = ar[9];
                o_nxt.p[FL_V] = ar[8];
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                if (op == OP_CMP) begin
                    cr = f_cmp(i_cur.a, i_operand);
                end else if (op == OP_CPX) begin
                    cr = f_cmp(i_cur.x, i_operand);
                end else begin
                    cr = f_cmp(i_cur.y, i_operand);
                end
                o_nxt.p[FL_C] = cr[2];
                o_nxt.p[FL_N] = cr[1];
                o_nxt.p[FL_Z] = cr[0];
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                sr = f_shift(t_shift'(i_operation[1:0] - 2'd2), sh_src, i_cur.p[FL_C]);
                o_nxt.p[FL_C] = sr[8];
                o_nxt.p[FL_Z] = (sr[7:0] == 8'h00);
                o_nxt.p[FL_N] = sr[7];
                if (i_on_accumulator) begin
                    o_nxt.a = sr[7:0];
                end else begin
                    o_store_data   = sr[7:0];
                    o_store_enable = 1'b1;
                end
            end
            OP_CLC: o_nxt.p[FL_C] = 1'b0;
            OP_SEC: o_nxt.p[FL_C] = 1'b1;
            OP_CLI: o_nxt.p[FL_I] = 1'b0;
            OP_SEI: o_nxt.p[FL_I] = 1'b1;
            OP_CLD: o_nxt.p[FL_D] = 1'b0;
            OP_SED: o_nxt.p[FL_D] = 1'b1;
            OP_CLV: o_nxt.p[FL_V] = 1'b0;
            OP_NOP: begin
            end
            OP_SLO, OP_RLA, OP_SRE: begin
                if (op == OP_SLO) begin
                    sr      = f_shift(SH_ASL, i_operand, i_cur.p[FL_C]);
                    o_nxt.a = i_cur.a | sr[7:0];
                end else if (op == OP_RLA) begin
                    sr      = f_shift(SH_ROL, i_operand, i_cur.p[FL_C]);
                    o_nxt.a = i_cur.a & sr[7:0];
                end else begin
                    sr      = f_shift(SH_LSR, i_operand, i_cur.p[FL_C]);
                    o_nxt.a = i_cur.a ^ sr[7:0];
                end
                o_nxt.p[FL_C]  = sr[8];
                o_store_data   = sr[7:0];
                o_store_enable = 1'b1;
            end
            OP_RRA: begin
                sr = f_shift(SH_ROR, i_operand, i_cur.p[FL_C]);
                ar = f_adc(i_cur.a, sr[7:0], sr[8]);
                o_nxt.a        = ar[7:0];
                o_nxt.p[FL_C]  = ar[9];
                o_nxt.p[FL_V]  = ar[8];
                o_store_data   = sr[7:0];
                o_store_enable = 1'b1;
            end
            OP_STA: begin
                o_store_data   = i_cur.a;
                o_store_enable = 1'b1;
            end
            OP_STX: begin
                o_store_data   = i_cur.x;
                o_store_enable = 1'b1;
            end
            OP_STY: begin
                o_store_data   = i_cur.y;
                o_store_enable = 1'b1;
            end
            default: begin
            end
        endcase

        // N and Z follow the register that the operation loaded
        unique case (op)
            OP_LDA, OP_TXA, OP_TYA, OP_ADC, OP_SBC, OP_SLO, OP_RLA, OP_SRE, OP_RRA: begin
                o_nxt.p[FL_Z] = (o_nxt.a == 8'h00);
                o_nxt.p[FL_N] = o_nxt.a[7];
            end
            OP_LDX, OP_TAX, OP_TSX: begin
                o_nxt.p[FL_Z] = (o_nxt.x == 8'h00);
                o_nxt.p[FL_N] = o_nxt.x[7];
            end
            OP_LDY, OP_TAY: begin
                o_nxt.p[FL_Z] = (o_nxt.y == 8'h00);
                o_nxt.p[FL_N] = o_nxt.y[7];
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/cpu_6502_alu_execute_core.sv
// Execute core of a 6502-style CPU: one operation per transaction, holding A, X, Y, SP
// and P. Accepts a new transaction every clock while the result side is not stalled; each
// result passes through the input register and then the result register around the ALU path.
// Depends on c6502alu_pkg and c6502alu_alu.
module cpu_6502_alu_execute_core
    import c6502alu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // operation[5:0], operand[13:6], zero fill
    input  logic        s_axis_tuser,  // on_accumulator
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // store_data, acc_out, x_out, y_out, sp_out, status_out
    output logic        m_axis_tuser   // store_enable
);

    logic        r_in_valid;
    logic [5:0]  r_operation;
    logic [7:0]  r_operand;
    logic        r_on_acc;
    t_regs       r_regs;
    t_regs       n_regs;
    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic        r_out_store_en;
    logic [7:0]  n_store_data;
    logic        n_store_en;
    logic        out_free;
    logic        advance;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    c6502alu_alu u_alu (
        .i_cur            (r_regs),
        .i_operation      (r_operation),
        .i_operand        (r_operand),
        .i_on_accumulator (r_on_acc),
        .o_nxt            (n_regs),
        .o_store_data     (n_store_data),
        .o_store_enable   (n_store_en)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_operation <= s_axis_tdata[5:0];
            r_operand   <= s_axis_tdata[13:6];
            r_on_acc    <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '{a: RST_A, x: RST_X, y: RST_Y, sp: RST_SP, p: RST_P};
        end else if (advance) begin
            r_regs <= n_regs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data     <= {n_regs.p, n_regs.sp, n_regs.y, n_regs.x, n_regs.a,
                               n_store_data};
            r_out_store_en <= n_store_en;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_store_en;

endmodule

FILE: rtl/c6502alu_chk.sv
// port-level checker for cpu_6502_alu_execute_core, attached by bind
// no package dependencies
module c6502alu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // b stays clear and u stays set
    a_bu_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[44] == 1'b0) && (m_axis_tdata[45] == 1'b1))
        else $error("b or u flag changed");

    // no store means zero store byte
    a_no_store_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("store byte not zero without store");

    // empty output side never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // accepted transaction into an empty output side yields a valid result when the receiver is ready
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid ##1 m_axis_tready |=>
            m_axis_tvalid)
        else $error("result missing after accept");

endmodule

bind cpu_6502_alu_execute_core c6502alu_chk u_c6502alu_chk (.*);

FILE: verif/cpu_6502_alu_checker.sv
// checker for the 6502-style execute core: watches both stream channels, predicts the
// register file after each accepted operation and compares every result in order
// depends on c6502alu_pkg
`timescale 1ns / 100ps

module cpu_6502_alu_checker
    import c6502alu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // operation[5:0], operand[13:6], zero fill
    input  logic        i_s_tuser,   // on_accumulator
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,   // store_data, acc_out, x_out, y_out, sp_out, status_out
    input  logic        i_m_tuser,   // store_enable
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] sp;
        logic [7:0] y;
        logic [7:0] x;
        logic [7:0] acc;
        logic [7:0] store_data;
        logic       store_en;
    } t_exec_result;

    logic [7:0] cpu_a;
    logic [7:0] cpu_x;
    logic [7:0] cpu_y;
    logic [7:0] cpu_sp;
    logic [7:0] cpu_p;

    t_exec_result exec_results_due[$];
    int           results_seen;

    function automatic void set_nz_flags(input logic [7:0] v);
        cpu_p[FL_Z] = (v == 8'h00);
        cpu_p[FL_N] = v[7];
    endfunction

    function automatic void add_into_acc(input logic [7:0] m);
        logic [8:0] sum;
        sum = {1'b0, cpu_a} + {1'b0, m} + {8'h00, cpu_p[FL_C]};
        cpu_p[FL_C] = sum[8];
        cpu_p[FL_V] = (sum[7] ^ cpu_a[7]) & (sum[7] ^ m[7]);
        set_nz_flags(sum[7:0]);
        cpu_a = sum[7:0];
    endfunction

    function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
        logic [7:0] diff;
        diff = r - m;
        cpu_p[FL_C] = (r >= m);
        cpu_p[FL_Z] = (r == m);
        cpu_p[FL_N] = diff[7];
    endfunction

    // updates carry, returns the shifted byte
    function automatic logic [7:0] shift_byte(input t_shift kind, input logic [7:0] v);
        logic       cin;
        logic [7:0] r;
        cin = cpu_p[FL_C];
        case (kind)
            SH_ASL: begin
                cpu_p[FL_C] = v[7];
                r = {v[6:0], 1'b0};
            end
            SH_LSR: begin
                cpu_p[FL_C] = v[0];
                r = {1'b0, v[7:1]};
            end
            SH_ROL: begin
                cpu_p[FL_C] = v[7];
                r = {v[6:0], cin};
            end
            default: begin
                cpu_p[FL_C] = v[0];
                r = {cin, v[7:1]};
            end
        endcase
        return r;
    endfunction

    function automatic t_exec_result exec_predict(input logic [5:0] op, input logic [7:0] m,
                                                  input logic on_a);
        t_exec_result res;
        logic [7:0]   r;
        res = '0;
        case (op)
            OP_LDA: begin cpu_a = m;      set_nz_flags(cpu_a); end
            OP_LDX: begin cpu_x = m;      set_nz_flags(cpu_x); end
            OP_LDY: begin cpu_y = m;      set_nz_flags(cpu_y); end
            OP_TAX: begin cpu_x = cpu_a;  set_nz_flags(cpu_x); end
            OP_TAY: begin cpu_y = cpu_a;  set_nz_flags(cpu_y); end
            OP_TSX: begin cpu_x = cpu_sp; set_nz_flags(cpu_x); end
            OP_TXA: begin cpu_a = cpu_x;  set_nz_flags(cpu_a); end
            OP_TXS: cpu_sp = cpu_x;
            OP_TYA: begin cpu_a = cpu_y;  set_nz_flags(cpu_a); end
            OP_ADC: add_into_acc(m);
            OP_SBC: add_into_acc(~m);
            OP_CMP: compare_reg(cpu_a, m);
            OP_CPX: compare_reg(cpu_x, m);
            OP_CPY: compare_reg(cpu_y, m);
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                r = shift_byte(t_shift'(2'(op - OP_ASL)), on_a ? cpu_a : m);
                set_nz_flags(r);
                if (on_a) begin
                    cpu_a = r;
                end else begin
                    res.store_data = r;
                    res.store_en = 1'b1;
                end
            end
            OP_CLC: cpu_p[FL_C] = 1'b0;
            OP_SEC: cpu_p[FL_C] = 1'b1;
            OP_CLI: cpu_p[FL_I] = 1'b0;
            OP_SEI: cpu_p[FL_I] = 1'b1;
            OP_CLD: cpu_p[FL_D] = 1'b0;
            OP_SED: cpu_p[FL_D] = 1'b1;
            OP_CLV: cpu_p[FL_V] = 1'b0;
            OP_SLO: begin
                r = shift_byte(SH_ASL, m);
                res.store_data = r;
                res.store_en = 1'b1;
                cpu_a = cpu_a | r;
                set_nz_flags(cpu_a);
            end
            OP_RLA: begin
                r = shift_byte(SH_ROL, m);
                res.store_data = r;
                res.store_en = 1'b1;
                cpu_a = cpu_a & r;
                set_nz_flags(cpu_a);
            end
            OP_SRE: begin
                r = shift_byte(SH_LSR, m);
                res.store_data = r;
                res.store_en = 1'b1;
                cpu_a = cpu_a ^ r;
                set_nz_flags(cpu_a);
            end
            OP_RRA: begin
                r = shift_byte(SH_ROR, m);
                res.store_data = r;
                res.store_en = 1'b1;
                add_into_acc(r);
            end
            OP_STA: begin res.store_data = cpu_a; res.store_en = 1'b1; end
            OP_STX: begin res.store_data = cpu_x; res.store_en = 1'b1; end
            OP_STY: begin res.store_data = cpu_y; res.store_en = 1'b1; end
            default: ;
        endcase
        res.acc    = cpu_a;
        res.x      = cpu_x;
        res.y      = cpu_y;
        res.sp     = cpu_sp;
        res.status = cpu_p;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] result %0d: %s got %02h expected %02h",
                 $realtime, results_seen, field, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        results_seen = 0;
    end

    always @(posedge i_clk) begin
        t_exec_result want;
        t_exec_result got;
        if (!i_rst_n) begin
            cpu_a  = RST_A;
            cpu_x  = RST_X;
            cpu_y  = RST_Y;
            cpu_sp = RST_SP;
            cpu_p  = RST_P;
            exec_results_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                exec_results_due.push_back(exec_predict(i_s_tdata[5:0], i_s_tdata[13:6],
                                                        i_s_tuser));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.store_data = i_m_tdata[7:0];
                got.acc        = i_m_tdata[15:8];
                got.x          = i_m_tdata[23:16];
                got.y          = i_m_tdata[31:24];
                got.sp         = i_m_tdata[39:32];
                got.status     = i_m_tdata[47:40];
                got.store_en   = i_m_tuser;
                if (exec_results_due.size() == 0) begin
                    report_mismatch("unexpected transaction, acc", got.acc, 8'h00);
                end else begin
                    want = exec_results_due.pop_front();
                    if (got.store_en !== want.store_en)
                        report_mismatch("store_enable", {7'h00, got.store_en},
                                        {7'h00, want.store_en});
                    if (got.store_data !== want.store_data)
                        report_mismatch("store_data", got.store_data, want.store_data);
                    if (got.acc !== want.acc)
                        report_mismatch("acc_out", got.acc, want.acc);
                    if (got.x !== want.x)
                        report_mismatch("x_out", got.x, want.x);
                    if (got.y !== want.y)
                        report_mismatch("y_out", got.y, want.y);
                    if (got.sp !== want.sp)
                        report_mismatch("sp_out", got.sp, want.sp);
                    if (got.status !== want.status)
                        report_mismatch("status_out", got.status, want.status);
                end
                results_seen++;
            end
        end
        o_pending = exec_results_due.size();
    end

endmodule

FILE: verif/tb_top.sv
// top of the execute core testbench: clock, reset, operation stimulus and ready pattern
// depends on c6502alu_pkg, cpu_6502_alu_execute_core and cpu_6502_alu_checker
`timescale 1ns / 100ps

module tb_top
    import c6502alu_pkg::*;
();

    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         RX_HOLD_CYCLES  = 60;
    localparam int         IDLE_PERCENT    = 33;
    localparam logic [5:0] OP_FIRST_UNUSED = 6'd33;
    localparam logic [5:0] OP_LAST_CODE    = 6'd63;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // operation[5:0], operand[13:6], zero fill
    logic        s_axis_tuser;   // on_accumulator
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // store_data, acc_out, x_out, y_out, sp_out, status_out
    logic        m_axis_tuser;   // store_enable

    int   fail_count;
    int   results_pending;
    int   items_sent;
    int   cycle_count;
    logic full_rate;
    logic rx_hold_req;
    logic rx_hold_done;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    cpu_6502_alu_execute_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cpu_6502_alu_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     results_pending);
            $display("tb_top failed");
            $finish;
        end
    end

    // receiver: random ready (always ready at full rate), one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        rx_hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && !rx_hold_done) begin
                m_axis_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_done = 1'b1;
            end
            m_axis_tready = full_rate ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic send_op(input logic [5:0] op, input logic [7:0] operand,
                           input logic on_a);
        while (!full_rate && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = {2'b00, operand, op};
        s_axis_tuser  = on_a;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_random_op();
        logic [5:0] op;
        logic [7:0] operand;
        if ($urandom_range(99) < 6)
            op = 6'($urandom_range(int'(OP_LAST_CODE), int'(OP_FIRST_UNUSED)));
        else
            op = 6'($urandom_range(int'(OP_STY), int'(OP_LDA)));
        case ($urandom_range(7))
            0: operand = 8'h00;
            1: operand = 8'hFF;
            2: operand = 8'h80;
            3: operand = 8'h7F;
            default: operand = 8'($urandom_range(255));
        endcase
        send_op(op, operand, 1'($urandom_range(1)));
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (results_pending != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        full_rate     = 1'b0;
        rx_hold_req   = 1'b0;
        items_sent    = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every operation, operand extremes, flag corners
        send_op(OP_TSX, 8'h00, 1'b0);
        send_op(OP_LDA, 8'h00, 1'b0);
        send_op(OP_LDA, 8'h80, 1'b1);
        send_op(OP_LDX, 8'hFF, 1'b0);
        send_op(OP_LDY, 8'h7F, 1'b0);
        send_op(OP_TXS, 8'h00, 1'b0);
        send_op(OP_TAX, 8'h00, 1'b0);
        send_op(OP_TYA, 8'h00, 1'b0);
        send_op(OP_TAY, 8'h00, 1'b0);
        send_op(OP_TXA, 8'h00, 1'b0);
        send_op(OP_LDA, 8'h7F, 1'b0);
        send_op(OP_SEC, 8'h00, 1'b0);
        send_op(OP_ADC, 8'h7F, 1'b0);
        send_op(OP_SBC, 8'hFF, 1'b0);
        send_op(OP_ADC, 8'hFF, 1'b0);
        send_op(OP_CMP, 8'hFF, 1'b0);
        send_op(OP_CPX, 8'h00, 1'b0);
        send_op(OP_CPY, 8'h7F, 1'b0);
        send_op(OP_ASL, 8'h80, 1'b0);
        send_op(OP_ROL, 8'h00, 1'b1);
        send_op(OP_ROR, 8'h01, 1'b0);
        send_op(OP_LSR, 8'hFF, 1'b1);
        send_op(OP_CLC, 8'h00, 1'b0);
        send_op(OP_SED, 8'h00, 1'b0);
        send_op(OP_CLD, 8'h00, 1'b0);
        send_op(OP_CLI, 8'h00, 1'b0);
        send_op(OP_SEI, 8'h00, 1'b0);
        send_op(OP_CLV, 8'h00, 1'b0);
        send_op(OP_NOP, 8'hFF, 1'b1);
        send_op(OP_SLO, 8'hC0, 1'b1);
        send_op(OP_RLA, 8'hFF, 1'b0);
        send_op(OP_SRE, 8'h01, 1'b1);
        send_op(OP_RRA, 8'hFF, 1'b0);
        send_op(OP_STA, 8'h00, 1'b0);
        send_op(OP_STX, 8'h00, 1'b1);
        send_op(OP_STY, 8'hFF, 1'b0);
        send_op(OP_LAST_CODE, 8'hFF, 1'b1);
        wait_drained();

        repeat (300) send_random_op();
        full_rate = 1'b1;
        repeat (200) send_random_op();

        // receiver stalls while the sender keeps offering at full rate
        rx_hold_req = 1'b1;
        repeat (60) send_random_op();
        wait_drained();
        full_rate = 1'b0;
        repeat (550) send_random_op();

        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("covered %0d transactions: all defined operations, unassigned codes and",
                 items_sent);
        $display("operand extremes, random idling, full-rate bursts and a %0d-cycle hold-off",
                 RX_HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
